/* hw/rtl/btndb_pkg.sv */
// Package for the button debouncer: payload and configuration types,
// register indexes and reset values.
// No dependencies; btndb_if, btndb_cfg, btndb_core, the top level and the testbench import it.
package btndb_pkg;

    // Default width of the debounce and long-press countdowns.
    localparam int CNT_W_DEF = 8;

    // Width of a configuration register and of the register index.
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_FIRST_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_REPEAT_DELAY = 2'd2;

    // Register reset values.
    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TICKS_RST    = 8'd5;
    localparam logic [CFG_DATA_W-1:0] LONG_FIRST_DELAY_RST  = 8'd100;
    localparam logic [CFG_DATA_W-1:0] LONG_REPEAT_DELAY_RST = 8'd20;

    // One input sample.
    typedef struct packed {
        logic raw_pressed;
        logic slow_tick;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic debounced_level;
        logic press_pulse;
        logic release_pulse;
        logic long_press_pulse;
        logic click_pulse;
    } t_out_item;

    // Current configuration handed from the register file to the core.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] debounce_ticks;
        logic [CFG_DATA_W-1:0] long_first_delay;
        logic [CFG_DATA_W-1:0] long_repeat_delay;
    } t_cfg;

endpackage

/* hw/rtl/btndb_if.sv */
// Channel interfaces of the button debouncer: input samples, results and
// configuration writes. Depends on btndb_pkg for widths.
interface btndb_in_if;
    logic valid;
    logic ready;
    logic raw_pressed;
    logic slow_tick;

    modport source (output valid, output raw_pressed, output slow_tick, input ready);
    modport sink   (input valid, input raw_pressed, input slow_tick, output ready);
endinterface

interface btndb_out_if;
    logic valid;
    logic ready;
    logic debounced_level;
    logic press_pulse;
    logic release_pulse;
    logic long_press_pulse;
    logic click_pulse;

    modport source (output valid, output debounced_level, output press_pulse,
                    output release_pulse, output long_press_pulse, output click_pulse,
                    input ready);
    modport sink   (input valid, input debounced_level, input press_pulse,
                    input release_pulse, input long_press_pulse, input click_pulse,
                    output ready);
endinterface

interface btndb_cfg_if
    import btndb_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* hw/rtl/btndb_cfg.sv */
// Configuration register file of the button debouncer.
// Depends on btndb_pkg for register indexes, reset values and t_cfg.
module btndb_cfg
    import btndb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Write decode; indexes past the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks    <= DEBOUNCE_TICKS_RST;
            r_cfg.long_first_delay  <= LONG_FIRST_DELAY_RST;
            r_cfg.long_repeat_delay <= LONG_REPEAT_DELAY_RST;
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_DEBOUNCE_TICKS:    r_cfg.debounce_ticks    <= i_wr_data;
                REG_LONG_FIRST_DELAY:  r_cfg.long_first_delay  <= i_wr_data;
                REG_LONG_REPEAT_DELAY: r_cfg.long_repeat_delay <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/btndb_core.sv */
// Debounce and long-press state machine of the button debouncer.
// Depends on btndb_pkg for t_in_item, t_out_item, t_cfg and reset values.
module btndb_core
    import btndb_pkg::*;
#(
    parameter int COUNT_WIDTH = CNT_W_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    // Width wide enough to compare a register value with the counter maximum.
    localparam int LW = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;
    localparam logic [LW-1:0] CNT_MAX = LW'((1 << COUNT_WIDTH) - 1);

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_PRESSING  = 2'd1,
        PH_HELD      = 2'd2,
        PH_RELEASING = 2'd3
    } t_phase;

    // Load a register value into a counter, saturating at its maximum.
    function automatic logic [COUNT_WIDTH-1:0] sat_load(input logic [CFG_DATA_W-1:0] v);
        logic [LW-1:0] ext;
        ext = LW'(v);
        if (ext > CNT_MAX) begin
            return '1;
        end
        return COUNT_WIDTH'(ext);
    endfunction

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_dc, n_dc;
    logic [COUNT_WIDTH-1:0] r_lc, n_lc;
    logic                   r_click, n_click;
    logic                   r_level, n_level;
    logic [COUNT_WIDTH-1:0] dc_dec, lc_dec;

    // Countdowns step first, then the phase logic looks at the stepped values.
    always_comb begin
        dc_dec = (r_dc != '0) ? r_dc - 1'b1 : '0;
        lc_dec = (i_item.slow_tick && (r_lc != '0)) ? r_lc - 1'b1 : r_lc;

        n_phase  = r_phase;
        n_dc     = dc_dec;
        n_lc     = lc_dec;
        n_click  = r_click;
        n_level  = r_level;
        o_result = '0;

        case (r_phase)
            PH_IDLE: begin
                if (i_item.raw_pressed) begin
                    n_dc    = sat_load(i_cfg.debounce_ticks);
                    n_phase = PH_PRESSING;
                end
            end
            PH_PRESSING: begin
                if (!i_item.raw_pressed) begin
                    n_phase = PH_IDLE;
                end else if (dc_dec == '0) begin
                    n_level              = 1'b1;
                    o_result.press_pulse = 1'b1;
                    n_click              = 1'b1;
                    n_lc                 = sat_load(i_cfg.long_first_delay);
                    n_phase              = PH_HELD;
                end
            end
            PH_HELD: begin
                if (!i_item.raw_pressed) begin
                    n_dc    = sat_load(i_cfg.debounce_ticks);
                    n_phase = PH_RELEASING;
                end else if (lc_dec == '0) begin
                    n_lc                      = sat_load(i_cfg.long_repeat_delay);
                    n_click                   = 1'b0;
                    o_result.long_press_pulse = 1'b1;
                end
            end
            PH_RELEASING: begin
                if (i_item.raw_pressed) begin
                    n_phase = PH_HELD;
                end else if (dc_dec == '0) begin
                    n_level                = 1'b0;
                    o_result.release_pulse = 1'b1;
                    o_result.click_pulse   = r_click;
                    n_click                = 1'b0;
                    n_phase                = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        o_result.debounced_level = n_level;
    end

    // State advances once per sample that moves to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_dc    <= sat_load(DEBOUNCE_TICKS_RST);
            r_lc    <= sat_load(LONG_FIRST_DELAY_RST);
            r_click <= 1'b0;
            r_level <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_dc    <= n_dc;
            r_lc    <= n_lc;
            r_click <= n_click;
            r_level <= n_level;
        end
    end

endmodule

/* hw/rtl/button_debounce_long_press_click_top.sv */
// Top level of the button debouncer with long-press and click detection.
// Depends on btndb_pkg, btndb_if, btndb_cfg and btndb_core.
//
//   Channel   Dir  Port   Payload
//   --------  ---  -----  -----------------------------------------------
//   samples   in   i_in   raw_pressed, slow_tick
//   results   out  o_out  debounced_level, press, release, long, click
//   config    in   i_cfg  index (2 bits), wdata (8 bits); always ready
//
// One sample per cycle unless the result channel stalls; each accepted sample
// gives one result, held first in the input register, then in the result
// register behind the state logic, which updates combinationally between them.
// A stalled result holds the pipe; the input register still takes one sample.
// Synchronous active-low reset clears state and loads register reset values.
module button_debounce_long_press_click_top
    import btndb_pkg::*;
#(
    parameter int COUNT_WIDTH = CNT_W_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    btndb_in_if.sink     i_in,
    btndb_out_if.source  o_out,
    btndb_cfg_if.sink    i_cfg
);

    t_cfg      cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_out_item result;
    logic      advance;
    logic      in_accept;

    // Register file.
    assign i_cfg.ready = 1'b1;

    btndb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.wdata),
        .o_cfg      (cfg)
    );

    // Handshake: the pipe moves when the result register is free or drained.
    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign in_accept  = i_in.valid && i_in.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
        end
        if (in_accept) begin
            r_in.raw_pressed <= i_in.raw_pressed;
            r_in.slow_tick   <= i_in.slow_tick;
        end
    end

    btndb_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_in_valid && advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (advance && r_in_valid) begin
            r_out <= result;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.debounced_level  = r_out.debounced_level;
    assign o_out.press_pulse      = r_out.press_pulse;
    assign o_out.release_pulse    = r_out.release_pulse;
    assign o_out.long_press_pulse = r_out.long_press_pulse;
    assign o_out.click_pulse      = r_out.click_pulse;

endmodule

/* hw/rtl/btndb_chk.sv */
// Port-level checks for the button debouncer, bound to the top level.
// Depends only on the top level's ports.
module btndb_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic level,
    input logic press,
    input logic release_p,
    input logic long_p,
    input logic click
);

    // A stalled result keeps its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid &&
        $stable({level, press, release_p, long_p, click}))
        else $error("result changed while stalled");

    // A press leaves the level high and is never a release or a long press at once.
    a_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && press |-> level && !release_p && !long_p)
        else $error("press pulse with wrong level or companion pulse");

    // A click only comes with a release.
    a_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && click |-> release_p && !level)
        else $error("click pulse without release");

    // A long press only fires while the button stays held.
    a_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && long_p |-> level && !release_p)
        else $error("long press pulse while not held");

endmodule

bind button_debounce_long_press_click_top btndb_chk u_btndb_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .level     (o_out.debounced_level),
    .press     (o_out.press_pulse),
    .release_p (o_out.release_pulse),
    .long_p    (o_out.long_press_pulse),
    .click     (o_out.click_pulse)
);

/* verif/button_debounce_long_press_click_top_test.sv */
// Testbench for button_debounce_long_press_click_top: drives sample transactions,
// predicts every result with its own debounce model and checks each one in order.
// Depends on btndb_pkg, btndb_if and the RTL of the block.
module button_debounce_long_press_click_top_test;
    import btndb_pkg::*;

    // Run control.
    localparam int CYCLE_LIMIT       = 500000;
    localparam int DRAIN_CYCLES      = 6;
    localparam int LONG_STALL_CYCLES = 64;

    // Register index that maps to no register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_IDX = 2'd3;

    // Debounce phases of the button.
    typedef enum logic [1:0] {
        BTN_UP,
        BTN_GOING_DOWN,
        BTN_DOWN,
        BTN_GOING_UP
    } t_btn_phase;

    logic i_clk;
    logic i_rst_n;

    btndb_in_if  in_if ();
    btndb_out_if out_if ();
    btndb_cfg_if cfg_if ();

    button_debounce_long_press_click_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Register settings as the block should hold them.
    logic [CFG_DATA_W-1:0] set_debounce;
    logic [CFG_DATA_W-1:0] set_first;
    logic [CFG_DATA_W-1:0] set_repeat;

    // Button state as the block should hold it.
    t_btn_phase            btn_phase;
    logic [CFG_DATA_W-1:0] bounce_left;
    logic [CFG_DATA_W-1:0] hold_left;
    logic                  click_armed;
    logic                  btn_level;

    // Button events still to come out of the block, oldest first.
    t_out_item pending_events[$];

    string field_names[5] = '{"click_pulse", "long_press_pulse", "release_pulse",
                              "press_pulse", "debounced_level"};

    int   fail_count      = 0;
    int   samples_sent    = 0;
    int   results_checked = 0;
    int   settings_used   = 0;
    int   cycle_count     = 0;
    logic idle_on         = 1'b1;
    logic long_stall_req  = 1'b0;

    // Clock with a period of 4.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Reset values of registers and state.
    task automatic reset_button_model();
        set_debounce = DEBOUNCE_TICKS_RST;
        set_first    = LONG_FIRST_DELAY_RST;
        set_repeat   = LONG_REPEAT_DELAY_RST;
        btn_phase    = BTN_UP;
        bounce_left  = DEBOUNCE_TICKS_RST;
        hold_left    = LONG_FIRST_DELAY_RST;
        click_armed  = 1'b0;
        btn_level    = 1'b0;
    endtask

    // Advance the button state by one sample and return the event it causes.
    // Both countdowns step first; the phase logic then sees the new counts.
    function automatic t_out_item predict_button_event(input logic raw, input logic slow);
        t_out_item ev;
        ev = '0;
        if (bounce_left != 0)
            bounce_left = bounce_left - 1'b1;
        if (slow && hold_left != 0)
            hold_left = hold_left - 1'b1;
        case (btn_phase)
            BTN_UP: begin
                if (raw) begin
                    bounce_left = set_debounce;
                    btn_phase   = BTN_GOING_DOWN;
                end
            end
            BTN_GOING_DOWN: begin
                if (!raw) begin
                    btn_phase = BTN_UP;
                end else if (bounce_left == 0) begin
                    btn_level      = 1'b1;
                    ev.press_pulse = 1'b1;
                    click_armed    = 1'b1;
                    hold_left      = set_first;
                    btn_phase      = BTN_DOWN;
                end
            end
            BTN_DOWN: begin
                if (!raw) begin
                    bounce_left = set_debounce;
                    btn_phase   = BTN_GOING_UP;
                end else if (hold_left == 0) begin
                    hold_left           = set_repeat;
                    click_armed         = 1'b0;
                    ev.long_press_pulse = 1'b1;
                end
            end
            default: begin
                if (raw) begin
                    btn_phase = BTN_DOWN;
                end else if (bounce_left == 0) begin
                    btn_level        = 1'b0;
                    ev.release_pulse = 1'b1;
                    ev.click_pulse   = click_armed;
                    click_armed      = 1'b0;
                    btn_phase        = BTN_UP;
                end
            end
        endcase
        ev.debounced_level = btn_level;
        return ev;
    endfunction

    // Send one sample transaction, after a random idle burst now and then.
    task automatic send_sample(input logic raw, input logic slow);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.raw_pressed <= raw;
        in_if.slow_tick   <= slow;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_events.push_back(predict_button_event(raw, slow));
        samples_sent++;
    endtask

    // Send a run of samples at one raw level; slow ticks come at the given rate.
    task automatic send_run(input logic raw, input int len, input int slow_pct,
                            inout int left);
        for (int k = 0; k < len && left > 0; k++) begin
            send_sample(raw, $urandom_range(1, 100) <= slow_pct);
            left--;
        end
    endtask

    // Random button gestures: mostly press, hold and release with contact bounce,
    // sized to the current settings so that presses, long presses and clicks occur.
    task automatic run_gestures(input int budget);
        int left;
        int slow_pct;
        int span;
        left = budget;
        while (left > 0) begin
            slow_pct = $urandom_range(10, 100);
            if ($urandom_range(0, 4) == 0) begin
                // Noise: raw level and slow tick both random.
                span = $urandom_range(1, 8);
                repeat (span) begin
                    if (left > 0) begin
                        send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                        left--;
                    end
                end
            end else begin
                // Bounce on the way down.
                repeat ($urandom_range(0, 3)) begin
                    send_run(1'b1, $urandom_range(1, 2), slow_pct, left);
                    send_run(1'b0, $urandom_range(1, 2), slow_pct, left);
                end
                // Hold, sometimes too short, otherwise long enough for long presses.
                if ($urandom_range(0, 3) == 0)
                    span = $urandom_range(1, int'(set_debounce) + 2);
                else
                    span = int'(set_debounce) + 2 + $urandom_range(0,
                           ((int'(set_first) + 2 * int'(set_repeat) + 4) * 100) / slow_pct);
                send_run(1'b1, span, slow_pct, left);
                // Bounce while held, then the release.
                repeat ($urandom_range(0, 2)) begin
                    send_run(1'b0, $urandom_range(1, int'(set_debounce) + 1), slow_pct, left);
                    send_run(1'b1, $urandom_range(1, 3), slow_pct, left);
                end
                if ($urandom_range(0, 3) == 0)
                    span = $urandom_range(1, int'(set_debounce) + 2);
                else
                    span = int'(set_debounce) + 2 + $urandom_range(0, 4);
                send_run(1'b0, span, slow_pct, left);
            end
        end
    endtask

    // Write one register through a configuration transaction.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.wdata <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            REG_DEBOUNCE_TICKS:    set_debounce = val;
            REG_LONG_FIRST_DELAY:  set_first    = val;
            REG_LONG_REPEAT_DELAY: set_repeat   = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Stop sending and wait until every expected event has come out.
    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Load a full set of registers once the block is idle.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] db,
                                  input logic [CFG_DATA_W-1:0] first,
                                  input logic [CFG_DATA_W-1:0] rep);
        wait_drained();
        write_reg(REG_DEBOUNCE_TICKS, db);
        write_reg(REG_LONG_FIRST_DELAY, first);
        write_reg(REG_LONG_REPEAT_DELAY, rep);
        write_reg(REG_SPARE_IDX, CFG_DATA_W'($urandom));
        settings_used++;
    endtask

    // Zero delays: press on the next sample, long pulses on every held sample,
    // clicks, and bounce back out of both debounce phases.
    task automatic test_zero_delays();
        apply_settings(8'd0, 8'd0, 8'd0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, 1'b1);
        send_sample(1'b1, 1'b1);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b0);
        // Release right after the press gives a click.
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b1);
        // Bounce while going down.
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        // Bounce while going up returns to held.
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b0);
    endtask

    task automatic test_reset_settings();
        apply_settings(DEBOUNCE_TICKS_RST, LONG_FIRST_DELAY_RST, LONG_REPEAT_DELAY_RST);
        run_gestures(150);
    endtask

    task automatic test_maximum_settings();
        apply_settings(8'd255, 8'd255, 8'd255);
        run_gestures(300);
    endtask

    task automatic test_zero_settings();
        apply_settings(8'd0, 8'd0, 8'd0);
        run_gestures(150);
    endtask

    // Receiver holds off for a long stretch while samples keep coming.
    task automatic test_output_stall();
        apply_settings(8'd2, 8'd4, 8'd3);
        long_stall_req = 1'b1;
        run_gestures(150);
    endtask

    task automatic test_mixed_settings();
        apply_settings(8'd1, 8'd0, 8'd7);
        run_gestures(150);
    endtask

    // Last part with no idling on either side.
    task automatic test_back_to_back();
        apply_settings(8'd3, 8'd6, 8'd2);
        idle_on = 1'b0;
        run_gestures(150);
    endtask

    // Result receiver: random stall bursts, plus one long hold-off on request.
    initial begin : result_ready
        forever begin
            @(negedge i_clk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(negedge i_clk);
                out_if.ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest expected event.
    always @(posedge i_clk) begin : check_results
        t_out_item got;
        t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = {out_if.debounced_level, out_if.press_pulse, out_if.release_pulse,
                   out_if.long_press_pulse, out_if.click_pulse};
            if (pending_events.size() == 0) begin
                $error("result %0b arrived with no event expected", got);
                fail_count++;
            end else begin
                want = pending_events.pop_front();
                for (int b = 4; b >= 0; b--) begin
                    if (got[b] !== want[b]) begin
                        $error("%s: expected %0b, got %0b", field_names[b], want[b], got[b]);
                        fail_count++;
                    end
                end
            end
            results_checked++;
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        in_if.valid       = 1'b0;
        in_if.raw_pressed = 1'b0;
        in_if.slow_tick   = 1'b0;
        out_if.ready      = 1'b1;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = REG_DEBOUNCE_TICKS;
        cfg_if.wdata      = '0;
        i_rst_n           = 1'b0;
        reset_button_model();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_delays();
        test_reset_settings();
        test_maximum_settings();
        test_zero_settings();
        test_output_stall();
        test_mixed_settings();
        test_back_to_back();
        wait_drained();

        $display("Checked %0d results from %0d samples over %0d register settings,",
                 results_checked, samples_sent, settings_used);
        $display("with idle bursts on both channels and a %0d-cycle output stall.",
                 LONG_STALL_CYCLES);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/btndb_pkg.sv
hw/rtl/btndb_if.sv
hw/rtl/btndb_cfg.sv
hw/rtl/btndb_core.sv
hw/rtl/button_debounce_long_press_click_top.sv
hw/rtl/btndb_chk.sv
verif/button_debounce_long_press_click_top_test.sv
